// File: hw/rtl/cmap_pkg.sv
package cmap_pkg;

  localparam int SMP_W  = 16;
  localparam int POS_W  = 12;
  localparam int STEP_W = $clog2(SMP_W);

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_HOLD
  } st_t;

endpackage

// File: hw/rtl/cmap_cell.sv
module cmap_cell
  import cmap_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cell_ctl_t        ctl,
  input  logic [SMP_W-1:0] d_in,
  output logic [SMP_W-1:0] q
);

  logic [SMP_W-1:0] q_r;
  logic [SMP_W-1:0] q_nxt;

  always_comb begin
    q_nxt = q_r;
    if (ctl.clear) begin
      q_nxt = '0;
    end else if (ctl.shift) begin
      q_nxt = d_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

// File: hw/rtl/cmap_div.sv
module cmap_div
  import cmap_pkg::*;
#(
  parameter int SUM_W = 22,
  parameter int CNT_W = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             done,
  output logic [SMP_W-1:0] quot
);

  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [SMP_W-1:0]  dq_r, dq_nxt;
  logic [CNT_W-1:0]  dvs_r, dvs_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W:0]    trial;
  logic              ge;

  always_comb begin
    trial    = {rem_r, dq_r[SMP_W-1]};
    ge       = trial >= {1'b0, dvs_r};
    rem_nxt  = rem_r;
    dq_nxt   = dq_r;
    dvs_nxt  = dvs_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = CNT_W'(dividend[SUM_W-1:SMP_W]);
      dq_nxt   = dividend[SMP_W-1:0];
      dvs_nxt  = divisor;
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = ge ? CNT_W'(trial - {1'b0, dvs_r}) : CNT_W'(trial);
      dq_nxt   = {dq_r[SMP_W-2:0], ge};
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(SMP_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dq_r  <= dq_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign quot = dq_r;

endmodule

// File: hw/rtl/centered_moving_average_peak_top.sv
// Output: the beat that completes a window starts the 16-step serial divider, and
// its average is registered out once the divider is done and the output is free.
// Throughput: a sample is taken every cycle while no average is due, otherwise
// once that average is emitted; a block's final sample flushes up to HALF_WINDOW averages.
// Reset: synchronous, active low; clears the sample chain, sums, counters and peak.
// The same state clears after the final average of every block.
module centered_moving_average_peak_top
  import cmap_pkg::*;
#(
  parameter int HALF_WINDOW = 20,
  parameter int MAX_BLOCK   = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [SMP_W-1:0] in_sample,
  input  logic             in_block_end,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [SMP_W-1:0] out_average,
  output logic [POS_W-1:0] out_position,
  output logic             out_final_res,
  output logic [SMP_W-1:0] out_peak_value,
  output logic [POS_W-1:0] out_peak_position
);

  localparam int SPAN  = 2 * HALF_WINDOW;
  localparam int SUM_W = SMP_W + $clog2(SPAN);
  localparam int CNT_W = $clog2(SPAN + 1);
  localparam int R_W   = $clog2(MAX_BLOCK);

  st_t              st_r, st_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [R_W-1:0]   rcv_r, rcv_nxt;
  logic [R_W-1:0]   pos_r, pos_nxt;
  logic [R_W-1:0]   end_r, end_nxt;
  logic             flush_r, flush_nxt;
  logic [SMP_W-1:0] best_r, best_nxt;
  logic [POS_W-1:0] bpos_r, bpos_nxt;

  logic             ov_r, ov_nxt;
  logic [SMP_W-1:0] oavg_r, oavg_nxt;
  logic [POS_W-1:0] opos_r, opos_nxt;
  logic             ofin_r, ofin_nxt;
  logic [SMP_W-1:0] opk_r, opk_nxt;
  logic [POS_W-1:0] opkp_r, opkp_nxt;

  cell_ctl_t        cctl;
  logic [SMP_W-1:0] head_d;
  logic [SMP_W-1:0] tap [SPAN];
  logic [SMP_W-1:0] tail;

  logic             div_start;
  logic             div_done;
  logic [SMP_W-1:0] div_q;

  logic             in_acc;
  logic             last;
  logic             slot_free;
  logic             emit;
  logic             better;
  logic             fin;

  genvar k;
  generate
    for (k = 0; k < SPAN; k++) begin : g_cell
      if (k == 0) begin : g_head
        cmap_cell u_cell (
          .clk  (clk),
          .rst_n(rst_n),
          .ctl  (cctl),
          .d_in (head_d),
          .q    (tap[k])
        );
      end else begin : g_body
        cmap_cell u_cell (
          .clk  (clk),
          .rst_n(rst_n),
          .ctl  (cctl),
          .d_in (tap[k-1]),
          .q    (tap[k])
        );
      end
    end
  endgenerate

  assign tail = tap[SPAN-1];

  cmap_div #(
    .SUM_W(SUM_W),
    .CNT_W(CNT_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(sum_nxt),
    .divisor (cnt_nxt),
    .done    (div_done),
    .quot    (div_q)
  );

  assign in_ready  = (st_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign slot_free = !ov_r || out_ready;
  assign last      = in_block_end || (rcv_r == R_W'(MAX_BLOCK - 1));
  assign better    = div_q > best_r;
  assign fin       = flush_r && (pos_r == end_r);
  assign head_d    = (st_r == ST_IDLE) ? in_sample : '0;

  always_comb begin
    emit = 1'b0;
    if (((st_r == ST_DIV) && div_done) || (st_r == ST_HOLD)) begin
      emit = slot_free;
    end
  end

  always_comb begin
    st_nxt     = st_r;
    sum_nxt    = sum_r;
    fill_nxt   = fill_r;
    cnt_nxt    = cnt_r;
    rcv_nxt    = rcv_r;
    pos_nxt    = pos_r;
    end_nxt    = end_r;
    flush_nxt  = flush_r;
    best_nxt   = best_r;
    bpos_nxt   = bpos_r;
    cctl       = '0;
    div_start  = 1'b0;
    ov_nxt     = out_ready ? 1'b0 : ov_r;
    oavg_nxt   = oavg_r;
    opos_nxt   = opos_r;
    ofin_nxt   = ofin_r;
    opk_nxt    = opk_r;
    opkp_nxt   = opkp_r;

    case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          cctl.shift = 1'b1;
          sum_nxt    = sum_r + SUM_W'(in_sample) - SUM_W'(tail);
          fill_nxt   = (fill_r == CNT_W'(SPAN)) ? fill_r : fill_r + 1'b1;
          cnt_nxt    = fill_nxt;
          rcv_nxt    = rcv_r + 1'b1;
          end_nxt    = rcv_r;
          flush_nxt  = last;
          if (last || ({1'b0, rcv_r} >= (R_W + 1)'(HALF_WINDOW - 1))) begin
            div_start = 1'b1;
            st_nxt    = ST_DIV;
          end
        end
      end
      ST_DIV, ST_HOLD: begin
        if (emit) begin
          ov_nxt   = 1'b1;
          oavg_nxt = div_q;
          opos_nxt = POS_W'(pos_r);
          ofin_nxt = fin;
          opk_nxt  = '0;
          opkp_nxt = '0;
          if (better) begin
            best_nxt = div_q;
            bpos_nxt = POS_W'(pos_r);
          end
          pos_nxt = pos_r + 1'b1;
          if (fin) begin
            opk_nxt    = best_nxt;
            opkp_nxt   = bpos_nxt;
            cctl.clear = 1'b1;
            sum_nxt    = '0;
            fill_nxt   = '0;
            cnt_nxt    = '0;
            rcv_nxt    = '0;
            pos_nxt    = '0;
            flush_nxt  = 1'b0;
            best_nxt   = '0;
            bpos_nxt   = '0;
            st_nxt     = ST_IDLE;
          end else if (flush_r) begin
            cctl.shift = 1'b1;
            sum_nxt    = sum_r - SUM_W'(tail);
            if ({1'b0, pos_r} >= (R_W + 1)'(HALF_WINDOW)) begin
              cnt_nxt = cnt_r - 1'b1;
            end
            div_start = 1'b1;
            st_nxt    = ST_DIV;
          end else begin
            st_nxt = ST_IDLE;
          end
        end else if (st_r == ST_DIV && div_done) begin
          st_nxt = ST_HOLD;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      sum_r   <= '0;
      fill_r  <= '0;
      cnt_r   <= '0;
      rcv_r   <= '0;
      pos_r   <= '0;
      end_r   <= '0;
      flush_r <= 1'b0;
      best_r  <= '0;
      bpos_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      sum_r   <= sum_nxt;
      fill_r  <= fill_nxt;
      cnt_r   <= cnt_nxt;
      rcv_r   <= rcv_nxt;
      pos_r   <= pos_nxt;
      end_r   <= end_nxt;
      flush_r <= flush_nxt;
      best_r  <= best_nxt;
      bpos_r  <= bpos_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    oavg_r <= oavg_nxt;
    opos_r <= opos_nxt;
    ofin_r <= ofin_nxt;
    opk_r  <= opk_nxt;
    opkp_r <= opkp_nxt;
  end

  assign out_valid         = ov_r;
  assign out_average       = oavg_r;
  assign out_position      = opos_r;
  assign out_final_res     = ofin_r;
  assign out_peak_value    = opk_r;
  assign out_peak_position = opkp_r;

endmodule
